// ----- design/pta_pkg.sv -----
// Shared types and constants of the power-of-two page allocator.
`timescale 1ns / 1ps

package pta_pkg;

    // Pool geometry.
    localparam int PAGE_COUNT  = 16;
    localparam int PAGE_W      = 4;
    localparam int PAGE_OFS_W  = 12;
    localparam int TOP_ORDER   = 12;
    localparam int MIN_ORDER   = 3;
    localparam int BLK_PAGE_W  = 9;
    localparam int BLK_W       = 13;
    localparam int LINK_W      = 14;
    localparam int BLOCK_COUNT = 8192;
    localparam int ORDER_W     = 4;
    localparam int COUNT_W     = 10;

    localparam logic [LINK_W-1:0] LINK_NULL = 14'd8192;
    localparam logic [4:0]        PAGE_NULL = 5'd16;
    localparam logic [15:0]       MAX_SIZE  = 16'd4096;

    // Result status codes.
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_SIZE   = 3'd1;
    localparam logic [2:0] ST_NO_PAGE    = 3'd2;
    localparam logic [2:0] ST_IGNORED    = 3'd3;
    localparam logic [2:0] ST_MISALIGNED = 3'd4;

    // Request function codes.
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       latch;
        logic       carve_start;
        logic       carve_step;
        logic       rd_head;
        logic       rd_cur;
        logic       pop_done;
        logic       walk_start;
        logic       walk_adv;
        logic       push;
        logic       rm_adv;
        logic       page_ret;
        logic       finish;
        logic [2:0] code;
    } pta_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_free;
        logic alloc_bad;
        logic head_null;
        logic stack_empty;
        logic free_ignored;
        logic misaligned;
        logic carve_last;
        logic cur_null;
        logic cur_hit;
        logic count_full;
        logic out_free;
    } pta_stat_t;

    // Block order for an allocation size: round up to 8 bytes, then to a power of two.
    function automatic logic [ORDER_W-1:0] size_order(input logic [15:0] size);
        logic [15:0]        sm1;
        logic [ORDER_W-1:0] o;
        sm1 = size - 16'd1;
        o   = ORDER_W'(MIN_ORDER);
        for (int i = MIN_ORDER; i < TOP_ORDER; i++)
        begin
            if (sm1[i])
            begin
                o = ORDER_W'(i + 1);
            end
        end
        return o;
    endfunction

endpackage

// ----- design/pta_req_if.sv -----
// Request channel: allocate or free beats.
`timescale 1ns / 1ps

interface pta_req_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [15:0] request_size;
    logic [15:0] block_address;

    modport source (output valid, func, request_size, block_address, input ready);
    modport sink   (input valid, func, request_size, block_address, output ready);
endinterface

// ----- design/pta_rsp_if.sv -----
// Response channel: one result beat per request.
`timescale 1ns / 1ps

interface pta_rsp_if;
    logic        valid;
    logic        ready;
    logic        granted;
    logic [15:0] result_address;
    logic [2:0]  status;

    modport source (output valid, granted, result_address, status, input ready);
    modport sink   (input valid, granted, result_address, status, output ready);
endinterface

// ----- design/pta_cfg_if.sv -----
// Configuration write channel for the page count register.
`timescale 1ns / 1ps

interface pta_cfg_if;
    logic       valid;
    logic       ready;
    logic [4:0] pages_in_use;

    modport source (output valid, pages_in_use, input ready);
    modport sink   (input valid, pages_in_use, output ready);
endinterface

// ----- design/pta_datapath.sv -----
// Allocator datapath: page stack, list heads, block link memory and result register.
`timescale 1ns / 1ps

module pta_datapath
(
    input  logic                clk,
    input  logic                rst_n,
    input  pta_pkg::pta_cmd_t   cmd,
    output pta_pkg::pta_stat_t  stat,
    input  logic                req_func,
    input  logic [15:0]         req_size,
    input  logic [15:0]         req_addr,
    input  logic                cfg_we,
    input  logic [4:0]          cfg_pages,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output logic                rsp_granted,
    output logic [15:0]         rsp_addr,
    output logic [2:0]          rsp_status
);

    localparam int NP = pta_pkg::PAGE_COUNT;
    localparam int NO = pta_pkg::TOP_ORDER + 1;

    // Pool state.
    logic [4:0]                    pages_reg;
    logic [4:0]                    top_reg;
    logic [4:0]                    slink_reg [NP];
    logic [pta_pkg::ORDER_W-1:0]   pbo_reg   [NP];
    logic [pta_pkg::LINK_W-1:0]    head_reg  [NO];
    logic [pta_pkg::LINK_W-1:0]    link_mem  [pta_pkg::BLOCK_COUNT];
    logic [pta_pkg::LINK_W-1:0]    rd_data_reg;

    // Per-request working registers.
    logic                          func_reg;
    logic [15:0]                   size_reg;
    logic [15:0]                   addr_reg;
    logic [pta_pkg::ORDER_W-1:0]   order_reg;
    logic [pta_pkg::PAGE_W-1:0]    page_reg;
    logic [pta_pkg::LINK_W-1:0]    cur_reg;
    logic [pta_pkg::BLK_W-1:0]     prev_reg;
    logic                          have_prev_reg;
    logic [pta_pkg::COUNT_W-1:0]   count_reg;
    logic [pta_pkg::BLK_W-1:0]     carve_blk_reg;
    logic [pta_pkg::COUNT_W-1:0]   carve_left_reg;
    logic [15:0]                   alloc_addr_reg;

    // Result register.
    logic                          out_valid_reg;
    logic [2:0]                    out_status_reg;
    logic [15:0]                   out_addr_reg;

    // Derived values for the current request.
    logic [4:0]                    n_pages;
    logic [pta_pkg::COUNT_W-1:0]   nb;
    logic [pta_pkg::COUNT_W-1:0]   step;
    logic [pta_pkg::BLK_W-1:0]     base;
    logic [pta_pkg::BLK_W-1:0]     idx;
    logic [pta_pkg::PAGE_OFS_W:0]  align_mask;
    logic [pta_pkg::LINK_W-1:0]    head_cur;
    logic                          cur_in_page;
    logic [pta_pkg::BLK_W-1:0]     rd_addr;
    logic [pta_pkg::PAGE_W-1:0]    top_page;

    assign n_pages     = (cfg_pages > 5'(NP)) ? 5'(NP) : cfg_pages;
    assign nb          = pta_pkg::COUNT_W'(13'd4096 >> order_reg);
    assign step        = pta_pkg::COUNT_W'(13'd1 << (order_reg - 4'(pta_pkg::MIN_ORDER)));
    assign base        = {page_reg, {pta_pkg::BLK_PAGE_W{1'b0}}};
    assign idx         = addr_reg[15:3];
    assign align_mask  = (13'd1 << order_reg) - 13'd1;
    assign head_cur    = head_reg[order_reg];
    assign cur_in_page = (cur_reg[pta_pkg::BLK_W-1:pta_pkg::BLK_PAGE_W] == page_reg);
    assign rd_addr     = cmd.rd_head ? head_cur[pta_pkg::BLK_W-1:0]
                                     : cur_reg[pta_pkg::BLK_W-1:0];
    assign top_page    = top_reg[pta_pkg::PAGE_W-1:0];

    // Status toward the controller.
    always_comb
    begin
        stat.is_free      = (func_reg == pta_pkg::FUNC_FREE);
        stat.alloc_bad    = (size_reg == 16'd0) || (size_reg > pta_pkg::MAX_SIZE);
        stat.head_null    = (head_cur == pta_pkg::LINK_NULL);
        stat.stack_empty  = (top_reg == pta_pkg::PAGE_NULL);
        stat.free_ignored = ({1'b0, addr_reg[15:12]} >= pages_reg) || (order_reg == '0);
        stat.misaligned   = (addr_reg[11:0] & align_mask[11:0]) != 12'd0;
        stat.carve_last   = (carve_left_reg == pta_pkg::COUNT_W'(1));
        stat.cur_null     = (cur_reg == pta_pkg::LINK_NULL);
        stat.cur_hit      = (cur_reg == {1'b0, idx});
        stat.count_full   = ({1'b0, count_reg} + 11'd1) >= {1'b0, nb};
        stat.out_free     = !out_valid_reg || rsp_ready;
    end

    // Link memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.carve_step)
        begin
            link_mem[carve_blk_reg] <= (carve_left_reg == pta_pkg::COUNT_W'(1))
                ? pta_pkg::LINK_NULL
                : {1'b0, carve_blk_reg + pta_pkg::BLK_W'(step)};
        end
        else if (cmd.push)
        begin
            link_mem[idx] <= head_cur;
        end
        else if (cmd.rm_adv && cur_in_page && have_prev_reg)
        begin
            link_mem[prev_reg] <= rd_data_reg;
        end
        if (cmd.rd_head || cmd.rd_cur)
        begin
            rd_data_reg <= link_mem[rd_addr];
        end
    end

    // Request working registers.
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            func_reg       <= req_func;
            size_reg       <= req_size;
            addr_reg       <= req_addr;
            order_reg      <= (req_func == pta_pkg::FUNC_FREE)
                              ? pbo_reg[req_addr[15:12]]
                              : pta_pkg::size_order(req_size);
            page_reg       <= req_addr[15:12];
            alloc_addr_reg <= 16'd0;
        end
        if (cmd.carve_start)
        begin
            page_reg       <= top_page;
            carve_blk_reg  <= {top_page, {pta_pkg::BLK_PAGE_W{1'b0}}};
            carve_left_reg <= nb;
        end
        if (cmd.carve_step)
        begin
            carve_blk_reg  <= carve_blk_reg + pta_pkg::BLK_W'(step);
            carve_left_reg <= carve_left_reg - pta_pkg::COUNT_W'(1);
            if (carve_left_reg == pta_pkg::COUNT_W'(1))
            begin
                alloc_addr_reg <= {page_reg, 12'd0};
            end
        end
        if (cmd.pop_done)
        begin
            alloc_addr_reg <= {head_cur[pta_pkg::BLK_W-1:0], 3'd0};
        end
        if (cmd.walk_start)
        begin
            cur_reg   <= head_cur;
            count_reg <= '0;
        end
        if (cmd.walk_adv)
        begin
            cur_reg <= rd_data_reg;
            if (cur_in_page)
            begin
                count_reg <= count_reg + pta_pkg::COUNT_W'(1);
            end
        end
        if (cmd.push)
        begin
            cur_reg       <= {1'b0, idx};
            have_prev_reg <= 1'b0;
        end
        if (cmd.rm_adv)
        begin
            cur_reg <= rd_data_reg;
            if (!cur_in_page)
            begin
                prev_reg      <= cur_reg[pta_pkg::BLK_W-1:0];
                have_prev_reg <= 1'b1;
            end
        end
    end

    // Pool state: rebuilt on reset and on a configuration write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pages_reg <= 5'(NP);
            top_reg   <= 5'(NP - 1);
            for (int i = 0; i < NP; i++)
            begin
                slink_reg[i] <= (i == 0) ? pta_pkg::PAGE_NULL : 5'(i - 1);
                pbo_reg[i]   <= '0;
            end
            for (int i = 0; i < NO; i++)
            begin
                head_reg[i] <= pta_pkg::LINK_NULL;
            end
        end
        else if (cfg_we)
        begin
            pages_reg <= n_pages;
            top_reg   <= (n_pages == 5'd0) ? pta_pkg::PAGE_NULL : n_pages - 5'd1;
            for (int i = 0; i < NP; i++)
            begin
                slink_reg[i] <= (i == 0) ? pta_pkg::PAGE_NULL : 5'(i - 1);
                pbo_reg[i]   <= '0;
            end
            for (int i = 0; i < NO; i++)
            begin
                head_reg[i] <= pta_pkg::LINK_NULL;
            end
        end
        else
        begin
            if (cmd.carve_start)
            begin
                top_reg           <= slink_reg[top_page];
                pbo_reg[top_page] <= order_reg;
            end
            if (cmd.carve_step && (carve_left_reg == pta_pkg::COUNT_W'(1)))
            begin
                head_reg[order_reg] <= (nb == pta_pkg::COUNT_W'(1))
                    ? pta_pkg::LINK_NULL
                    : {1'b0, base + pta_pkg::BLK_W'(step)};
            end
            if (cmd.pop_done)
            begin
                head_reg[order_reg] <= rd_data_reg;
            end
            if (cmd.push)
            begin
                head_reg[order_reg] <= {1'b0, idx};
            end
            if (cmd.rm_adv && cur_in_page && !have_prev_reg)
            begin
                head_reg[order_reg] <= rd_data_reg;
            end
            if (cmd.page_ret)
            begin
                slink_reg[page_reg] <= top_reg;
                top_reg             <= {1'b0, page_reg};
                pbo_reg[page_reg]   <= '0;
            end
        end
    end

    // Result register: holds a finished beat until the sink takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_status_reg <= cmd.code;
            out_addr_reg   <= (cmd.code == pta_pkg::ST_OK) ? alloc_addr_reg : 16'd0;
        end
    end

    assign rsp_valid   = out_valid_reg;
    assign rsp_granted = (out_status_reg == pta_pkg::ST_OK);
    assign rsp_addr    = out_addr_reg;
    assign rsp_status  = out_status_reg;

endmodule

// ----- design/pta_ctrl.sv -----
// Allocator controller: sequences decode, carving, list walks and result handoff.
`timescale 1ns / 1ps

module pta_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    output logic                cfg_ready,
    input  pta_pkg::pta_stat_t  stat,
    output pta_pkg::pta_cmd_t   cmd
);

    typedef enum logic [10:0] {
        S_IDLE     = 11'b000_0000_0001,
        S_DECODE   = 11'b000_0000_0010,
        S_CARVE    = 11'b000_0000_0100,
        S_POP_RD   = 11'b000_0000_1000,
        S_POP_WAIT = 11'b000_0001_0000,
        S_WALK_RD  = 11'b000_0010_0000,
        S_WALK_CHK = 11'b000_0100_0000,
        S_PUSH     = 11'b000_1000_0000,
        S_RM_RD    = 11'b001_0000_0000,
        S_RM_CHK   = 11'b010_0000_0000,
        S_FINISH   = 11'b100_0000_0000
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    logic [2:0] code_reg;
    logic [2:0] code_next;

    assign req_ready = (state_reg == S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        code_next  = code_reg;
        cmd        = '0;
        cmd.code   = code_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_FINISH;
                if (stat.is_free)
                begin
                    if (stat.free_ignored)
                    begin
                        code_next = pta_pkg::ST_IGNORED;
                    end
                    else if (stat.misaligned)
                    begin
                        code_next = pta_pkg::ST_MISALIGNED;
                    end
                    else
                    begin
                        cmd.walk_start = 1'b1;
                        state_next     = S_WALK_RD;
                    end
                end
                else if (stat.alloc_bad)
                begin
                    code_next = pta_pkg::ST_BAD_SIZE;
                end
                else if (!stat.head_null)
                begin
                    state_next = S_POP_RD;
                end
                else if (stat.stack_empty)
                begin
                    code_next = pta_pkg::ST_NO_PAGE;
                end
                else
                begin
                    cmd.carve_start = 1'b1;
                    state_next      = S_CARVE;
                end
            end
            S_CARVE:
            begin
                cmd.carve_step = 1'b1;
                if (stat.carve_last)
                begin
                    code_next  = pta_pkg::ST_OK;
                    state_next = S_FINISH;
                end
            end
            S_POP_RD:
            begin
                cmd.rd_head = 1'b1;
                state_next  = S_POP_WAIT;
            end
            S_POP_WAIT:
            begin
                cmd.pop_done = 1'b1;
                code_next    = pta_pkg::ST_OK;
                state_next   = S_FINISH;
            end
            S_WALK_RD:
            begin
                if (stat.cur_null)
                begin
                    state_next = S_PUSH;
                end
                else if (stat.cur_hit)
                begin
                    code_next  = pta_pkg::ST_IGNORED;
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.rd_cur = 1'b1;
                    state_next = S_WALK_CHK;
                end
            end
            S_WALK_CHK:
            begin
                cmd.walk_adv = 1'b1;
                state_next   = S_WALK_RD;
            end
            S_PUSH:
            begin
                cmd.push  = 1'b1;
                code_next = pta_pkg::ST_OK;
                state_next = stat.count_full ? S_RM_RD : S_FINISH;
            end
            S_RM_RD:
            begin
                if (stat.cur_null)
                begin
                    cmd.page_ret = 1'b1;
                    state_next   = S_FINISH;
                end
                else
                begin
                    cmd.rd_cur = 1'b1;
                    state_next = S_RM_CHK;
                end
            end
            S_RM_CHK:
            begin
                cmd.rm_adv = 1'b1;
                state_next = S_RM_RD;
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            code_reg  <= pta_pkg::ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

endmodule

// ----- design/power_of_two_page_allocator_top.sv -----
// Top level of the power-of-two page allocator.
`timescale 1ns / 1ps

// A pool of 16 pages of 4096 bytes is split on demand into power-of-two blocks
// (8 to 4096 bytes), with one LIFO free list per block size and a LIFO stack of
// free pages; each request beat returns exactly one response beat. One request
// is in flight at a time, and every list step goes through the block link
// memory. An allocate served from a list pops the list head; one that carves a
// fresh page writes one link per block. A free walks the size's whole free list,
// and when it completes a page it walks the list once more to unlink that page's
// blocks. A configuration write rebuilds the page stack and is taken only while
// no request is in progress.

module power_of_two_page_allocator_top
(
    input  logic        clk,
    input  logic        rst_n,
    pta_req_if.sink     req,
    pta_rsp_if.source   rsp,
    pta_cfg_if.sink     cfg
);

    pta_pkg::pta_cmd_t  cmd;
    pta_pkg::pta_stat_t stat;
    logic               cfg_ready_int;

    assign cfg.ready = cfg_ready_int;

    // Sequencer.
    pta_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .cfg_ready (cfg_ready_int),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Storage and arithmetic.
    pta_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .req_func    (req.func),
        .req_size    (req.request_size),
        .req_addr    (req.block_address),
        .cfg_we      (cfg.valid && cfg_ready_int),
        .cfg_pages   (cfg.pages_in_use),
        .rsp_valid   (rsp.valid),
        .rsp_ready   (rsp.ready),
        .rsp_granted (rsp.granted),
        .rsp_addr    (rsp.result_address),
        .rsp_status  (rsp.status)
    );

endmodule

// ----- verif/power_of_two_page_allocator_top_tb.sv -----
// Self-checking testbench for the power-of-two page allocator top level.
`timescale 1ns / 1ps

module power_of_two_page_allocator_top_tb;

    localparam int BLOCKS_PER_PAGE = 512;
    localparam int IDLE_LIMIT      = 100000;

    typedef struct packed {
        logic        granted;
        logic [15:0] result_address;
        logic [2:0]  status;
    } alloc_result_t;

    logic clk;
    logic rst_n;

    pta_req_if req ();
    pta_rsp_if rsp ();
    pta_cfg_if cfg ();

    power_of_two_page_allocator_top dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    // Shadow copy of the allocator state.
    int unsigned pool_pages;
    int unsigned stack_link [pta_pkg::PAGE_COUNT];
    int unsigned stack_top;
    int unsigned page_order [pta_pkg::PAGE_COUNT];
    int unsigned free_head [pta_pkg::TOP_ORDER + 1];
    int unsigned block_next [pta_pkg::BLOCK_COUNT];

    alloc_result_t pending_results[$];
    logic [15:0]   live_blocks[$];
    int            error_count;
    int            beats_checked;
    int            status_seen [8];
    int            idle_cycles;
    int            burst_left;
    logic          req_on;

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Shadow state rebuild, as done on reset and on every register write.
    function automatic void rebuild_pool(input int unsigned pages);
        pool_pages = pages;
        for (int i = 0; i < pta_pkg::PAGE_COUNT; i++)
        begin
            page_order[i] = 0;
            stack_link[i] = 0;
        end
        for (int i = 0; i < pta_pkg::BLOCK_COUNT; i++)
        begin
            block_next[i] = 0;
        end
        for (int i = 0; i <= pta_pkg::TOP_ORDER; i++)
        begin
            free_head[i] = pta_pkg::BLOCK_COUNT;
        end
        stack_top = pta_pkg::PAGE_COUNT;
        for (int i = 0; i < pages; i++)
        begin
            stack_link[i] = stack_top;
            stack_top     = i;
        end
    endfunction

    function automatic int unsigned link_after(input int unsigned b);
        if (b >= pta_pkg::BLOCK_COUNT)
        begin
            return pta_pkg::BLOCK_COUNT;
        end
        return block_next[b];
    endfunction

    // Allocation: round the size, pop the list, carving a page when it is empty.
    function automatic alloc_result_t predict_alloc(input logic [15:0] size);
        alloc_result_t r;
        int unsigned   aligned;
        int unsigned   order;
        int unsigned   page;
        int unsigned   base;
        int unsigned   stride;
        int unsigned   count;
        r = '{1'b0, 16'd0, pta_pkg::ST_BAD_SIZE};
        if (size == 0 || size > pta_pkg::MAX_SIZE)
        begin
            return r;
        end
        aligned = (int'(size) + 7) & ~7;
        order   = pta_pkg::MIN_ORDER;
        while ((1 << order) < aligned)
        begin
            order++;
        end
        if (free_head[order] == pta_pkg::BLOCK_COUNT)
        begin
            if (stack_top >= pta_pkg::PAGE_COUNT)
            begin
                r.status = pta_pkg::ST_NO_PAGE;
                return r;
            end
            page              = stack_top;
            stack_top         = stack_link[page];
            page_order[page]  = order;
            base              = page * BLOCKS_PER_PAGE;
            stride            = 1 << (order - pta_pkg::MIN_ORDER);
            count             = 4096 >> order;
            for (int i = 0; i < count; i++)
            begin
                block_next[base + i * stride] =
                    (i + 1 < count) ? base + (i + 1) * stride : pta_pkg::BLOCK_COUNT;
            end
            free_head[order] = base;
        end
        base             = free_head[order];
        free_head[order] = link_after(base);
        r.granted        = 1'b1;
        r.result_address = 16'(base * 8);
        r.status         = pta_pkg::ST_OK;
        return r;
    endfunction

    // Free: check the block, push it, and return its page once it is whole.
    function automatic alloc_result_t predict_free(input logic [15:0] addr);
        alloc_result_t r;
        int unsigned   page;
        int unsigned   order;
        int unsigned   idx;
        int unsigned   base;
        int unsigned   count;
        int unsigned   b;
        int unsigned   nx;
        int unsigned   prev;
        bit            have_prev;
        r    = '{1'b0, 16'd0, pta_pkg::ST_IGNORED};
        page = addr / 4096;
        if (page >= pool_pages)
        begin
            return r;
        end
        order = page_order[page];
        if (order < pta_pkg::MIN_ORDER || order > pta_pkg::TOP_ORDER)
        begin
            return r;
        end
        if ((addr % 4096) & ((1 << order) - 1))
        begin
            r.status = pta_pkg::ST_MISALIGNED;
            return r;
        end
        idx   = addr >> 3;
        base  = page * BLOCKS_PER_PAGE;
        count = 0;
        b     = free_head[order];
        for (int g = 0; b != pta_pkg::BLOCK_COUNT && g < pta_pkg::BLOCK_COUNT; g++)
        begin
            if (b == idx)
            begin
                return r;
            end
            if (b >= base && b < base + BLOCKS_PER_PAGE)
            begin
                count++;
            end
            b = link_after(b);
        end
        block_next[idx]  = free_head[order];
        free_head[order] = idx;
        count++;
        if (count >= (4096 >> order))
        begin
            have_prev = 1'b0;
            prev      = 0;
            b         = free_head[order];
            for (int g = 0; b != pta_pkg::BLOCK_COUNT && g < pta_pkg::BLOCK_COUNT; g++)
            begin
                nx = link_after(b);
                if (b >= base && b < base + BLOCKS_PER_PAGE)
                begin
                    if (have_prev)
                    begin
                        block_next[prev] = nx;
                    end
                    else
                    begin
                        free_head[order] = nx;
                    end
                end
                else
                begin
                    prev      = b;
                    have_prev = 1'b1;
                end
                b = nx;
            end
            stack_link[page] = stack_top;
            stack_top        = page;
            page_order[page] = 0;
        end
        r.granted = 1'b1;
        r.status  = pta_pkg::ST_OK;
        return r;
    endfunction

    // Mismatch reporting.
    task automatic report_mismatch(input string field, input int got, input int want);
        error_count++;
        $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, field, got, want);
    endtask

    // Result checker: each response beat against the oldest expectation.
    always @(posedge clk)
    begin
        alloc_result_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected response beats", 1, 0);
            end
            else
            begin
                want = pending_results.pop_front();
                beats_checked++;
                status_seen[want.status]++;
                if (rsp.granted !== want.granted)
                begin
                    report_mismatch("granted", rsp.granted, want.granted);
                end
                if (rsp.result_address !== want.result_address)
                begin
                    report_mismatch("result_address", rsp.result_address, want.result_address);
                end
                if (rsp.status !== want.status)
                begin
                    report_mismatch("status", rsp.status, want.status);
                end
            end
        end
    end

    // Response stall pattern: a randomly drawn mode, one of which never stalls.
    always @(negedge clk)
    begin
        static int stall_mode = 0;
        static int phase      = 0;
        phase++;
        if (phase % 64 == 0)
        begin
            stall_mode = $urandom_range(0, 3);
        end
        case (stall_mode)
            0: rsp.ready <= 1'b1;
            1: rsp.ready <= ($urandom_range(0, 99) >= 30);
            2: rsp.ready <= (phase % 5 != 0);
            default: rsp.ready <= (phase % 16 >= 10);
        endcase
    end

    // Watchdog on cycles with no beat on any channel.
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("Timeout after %0d idle cycles", IDLE_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Lower the request valid; called at a falling edge.
    task automatic release_req();
        if (req_on)
        begin
            req.valid <= 1'b0;
            req_on = 1'b0;
        end
    endtask

    // Send one request beat and record its expected result. Returns at a
    // falling edge with valid still high so a following beat can run back to back.
    task automatic send_request(input logic func, input logic [15:0] size,
                                input logic [15:0] addr);
        alloc_result_t want;
        if (burst_left <= 0)
        begin
            release_req();
            repeat ($urandom_range(1, 12)) @(negedge clk);
            burst_left = $urandom_range(1, 20);
        end
        req.func          <= func;
        req.request_size  <= size;
        req.block_address <= addr;
        if (!req_on)
        begin
            req.valid <= 1'b1;
            req_on = 1'b1;
        end
        @(posedge clk);
        while (!req.ready)
        begin
            @(posedge clk);
        end
        want = (func == pta_pkg::FUNC_ALLOC) ? predict_alloc(size) : predict_free(addr);
        pending_results.push_back(want);
        if (want.granted && func == pta_pkg::FUNC_ALLOC)
        begin
            live_blocks.push_back(want.result_address);
        end
        else if (want.granted)
        begin
            foreach (live_blocks[i])
            begin
                if (live_blocks[i] == addr)
                begin
                    live_blocks.delete(i);
                    break;
                end
            end
        end
        burst_left--;
        @(negedge clk);
    endtask

    // Hold off requests until every expected result has come back.
    task automatic drain_results();
        release_req();
        while (pending_results.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    // Register write while idle.
    task automatic write_page_count(input logic [4:0] pages);
        drain_results();
        cfg.pages_in_use <= pages;
        cfg.valid        <= 1'b1;
        @(posedge clk);
        while (!cfg.ready)
        begin
            @(posedge clk);
        end
        rebuild_pool((pages > pta_pkg::PAGE_COUNT) ? pta_pkg::PAGE_COUNT : pages);
        live_blocks.delete();
        @(negedge clk);
        cfg.valid <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [15:0] size_of_order(input int order);
        if (order == pta_pkg::MIN_ORDER)
        begin
            return 16'($urandom_range(1, 8));
        end
        return 16'($urandom_range((1 << (order - 1)) + 1, 1 << order));
    endfunction

    // Directed: size extremes, rounding, bad sizes, misaligned and double frees.
    task automatic test_sizes_and_frees();
        logic [15:0] a;
        logic [15:0] b;
        send_request(pta_pkg::FUNC_ALLOC, 16'd1, 16'd0);
        a = live_blocks[live_blocks.size() - 1];
        send_request(pta_pkg::FUNC_ALLOC, 16'd8, 16'd0);
        send_request(pta_pkg::FUNC_ALLOC, 16'd9, 16'd0);
        send_request(pta_pkg::FUNC_ALLOC, 16'd4096, 16'd0);
        b = live_blocks[live_blocks.size() - 1];
        send_request(pta_pkg::FUNC_ALLOC, 16'd4095, 16'd0);
        send_request(pta_pkg::FUNC_ALLOC, 16'd0, 16'hFFFF);
        send_request(pta_pkg::FUNC_ALLOC, 16'd4097, 16'd0);
        send_request(pta_pkg::FUNC_ALLOC, 16'hFFFF, 16'd0);
        send_request(pta_pkg::FUNC_FREE, 16'hFFFF, a + 16'd4);
        send_request(pta_pkg::FUNC_FREE, 16'd0, a);
        send_request(pta_pkg::FUNC_FREE, 16'd0, a);
        send_request(pta_pkg::FUNC_FREE, 16'd0, b + 16'd8);
        send_request(pta_pkg::FUNC_FREE, 16'd0, b);
        send_request(pta_pkg::FUNC_FREE, 16'd0, 16'd0);
        send_request(pta_pkg::FUNC_FREE, 16'd0, 16'hFFFF);
    endtask

    // Directed: a tiny pool runs dry, frees beyond it are ignored, then saturation.
    task automatic test_pool_limits();
        write_page_count(5'd1);
        send_request(pta_pkg::FUNC_ALLOC, 16'd4096, 16'd0);
        send_request(pta_pkg::FUNC_ALLOC, 16'd4096, 16'd0);
        send_request(pta_pkg::FUNC_ALLOC, 16'd8, 16'd0);
        send_request(pta_pkg::FUNC_FREE, 16'd0, 16'd4096);
        send_request(pta_pkg::FUNC_FREE, 16'd0, 16'd0);
        send_request(pta_pkg::FUNC_ALLOC, 16'd2048, 16'd0);
        send_request(pta_pkg::FUNC_ALLOC, 16'd2048, 16'd0);
        send_request(pta_pkg::FUNC_FREE, 16'd0, 16'd2048);
        send_request(pta_pkg::FUNC_FREE, 16'd0, 16'd0);
        write_page_count(5'd0);
        send_request(pta_pkg::FUNC_ALLOC, 16'd16, 16'd0);
        send_request(pta_pkg::FUNC_FREE, 16'd0, 16'd0);
        write_page_count(5'd31);
        send_request(pta_pkg::FUNC_ALLOC, 16'd4096, 16'd0);
        send_request(pta_pkg::FUNC_FREE, 16'd0, 16'd61440);
    endtask

    // Random mix: mostly well-formed allocate/free traffic plus broken requests.
    task automatic test_random_traffic(input int items, input int drain_at);
        int          pick;
        int          j;
        logic [15:0] addr;
        for (int n = 0; n < items; n++)
        begin
            if (n == drain_at)
            begin
                drain_results();
            end
            pick = $urandom_range(0, 99);
            if (live_blocks.size() > 48)
            begin
                pick = 50;
            end
            if (pick < 45)
            begin
                send_request(pta_pkg::FUNC_ALLOC,
                             size_of_order($urandom_range(pta_pkg::MIN_ORDER,
                                                          pta_pkg::TOP_ORDER)),
                             16'($urandom));
            end
            else if (pick < 85 && live_blocks.size() != 0)
            begin
                j = $urandom_range(0, live_blocks.size() - 1);
                send_request(pta_pkg::FUNC_FREE, 16'($urandom), live_blocks[j]);
            end
            else if (pick < 90)
            begin
                send_request(pta_pkg::FUNC_ALLOC, 16'($urandom), 16'($urandom));
            end
            else if (pick < 95 && live_blocks.size() != 0)
            begin
                addr = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
                send_request(pta_pkg::FUNC_FREE, 16'($urandom),
                             addr ^ (16'd1 << $urandom_range(0, 11)));
            end
            else
            begin
                send_request(pta_pkg::FUNC_FREE, 16'($urandom), 16'($urandom));
            end
        end
    endtask

    // Test sequence.
    initial
    begin
        rst_n            = 1'b0;
        req.valid        = 1'b0;
        req.func         = pta_pkg::FUNC_ALLOC;
        req.request_size = 16'd0;
        req.block_address = 16'd0;
        cfg.valid        = 1'b0;
        cfg.pages_in_use = 5'd0;
        req_on           = 1'b0;
        burst_left       = 0;
        error_count      = 0;
        beats_checked    = 0;
        idle_cycles      = 0;
        rebuild_pool(pta_pkg::PAGE_COUNT);
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_sizes_and_frees();
        test_pool_limits();
        write_page_count(5'd16);
        test_random_traffic(200, 120);
        write_page_count(5'd3);
        test_random_traffic(100, -1);
        write_page_count(5'($urandom_range(0, 31)));
        test_random_traffic(100, -1);
        write_page_count(5'd16);
        test_random_traffic(150, -1);

        drain_results();
        repeat (50) @(posedge clk);
        $display("Checked %0d response beats: %0d ok, %0d bad size, %0d no page,",
                 beats_checked, status_seen[pta_pkg::ST_OK], status_seen[pta_pkg::ST_BAD_SIZE],
                 status_seen[pta_pkg::ST_NO_PAGE]);
        $display("%0d ignored frees and %0d misaligned frees over several page counts.",
                 status_seen[pta_pkg::ST_IGNORED], status_seen[pta_pkg::ST_MISALIGNED]);
        if (error_count == 0 && pending_results.size() == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ----- files.f -----
design/pta_pkg.sv
design/pta_req_if.sv
design/pta_rsp_if.sv
design/pta_cfg_if.sv
design/pta_datapath.sv
design/pta_ctrl.sv
design/power_of_two_page_allocator_top.sv
verif/power_of_two_page_allocator_top_tb.sv
